// File: hdl/analog_stick_conditioner_core_macros.svh
// Assertion macros shared by the stick conditioner RTL.
`ifndef ANALOG_STICK_CONDITIONER_CORE_MACROS_SVH
`define ANALOG_STICK_CONDITIONER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ASC_ASSERT_IMPL(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ASC_ASSERT_NEXT(name, clk_s, rstn_s, ante, cons, msg) \
  name: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/asc_pkg.sv
// Types, constants and the throttle curve table of the stick conditioner.
package asc_pkg;

  localparam int SAMPLE_BITS = 12;
  localparam int DZ_W        = 11;
  localparam int PCT_W       = 8;
  localparam int PMAG_W      = 7;
  localparam int FRAC_BITS   = 8;
  localparam int R2_W        = 2 * SAMPLE_BITS + 1;
  localparam int ROOT_W      = R2_W + 2 * FRAC_BITS;
  localparam int MAG_W       = (ROOT_W + 1) / 2;

  localparam int DIV_NUM_W   = SAMPLE_BITS + 2 * FRAC_BITS;
  localparam int DIV_DEN_W   = MAG_W;
  localparam int DIV_QUO_W   = SAMPLE_BITS;

  localparam int CURVE_LEN   = 257;
  localparam int Q_W         = 9;

  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 12;

  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEAD_ZONE  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_FULL_RANGE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_EDGE_ZONE  = 3'd4;

  localparam logic [SAMPLE_BITS-1:0] CENTER_RST     = 12'd2048;
  localparam logic [DZ_W-1:0]        DEAD_ZONE_RST  = 11'd100;
  localparam logic [SAMPLE_BITS-1:0] FULL_RANGE_RST = 12'd2048;
  localparam logic [SAMPLE_BITS-1:0] EDGE_ZONE_RST  = 12'd100;

  localparam logic [PMAG_W-1:0] PCT_SCALE = 7'd100;
  localparam logic [Q_W-1:0]    Q_MAX     = Q_W'(CURVE_LEN - 1);
  localparam logic [ROOT_W-1:0] ROOT_TOP  = {1'b1, {(ROOT_W-1){1'b0}}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_UPD,
    ST_MEAN,
    ST_DEAD,
    ST_SQ_X,
    ST_SQ_Y,
    ST_ROOT_INIT,
    ST_ROOT,
    ST_BAND,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_Q_GO,
    ST_Q_WAIT,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_NUM_W-1:0] num;
    logic [DIV_DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                 busy;
    logic [DIV_QUO_W-1:0] quo;
  } div_rsp_t;

  typedef logic [PMAG_W-1:0] curve_t [CURVE_LEN];

  // e^(1/128) in Q30, six-term Taylor series with truncated terms
  localparam logic [63:0] Q30_ONE  = 64'd1073741824;
  localparam logic [63:0] Q30_RATE = 64'd1082163285;

  function automatic logic [63:0] curve_e(input int n);
    logic [63:0] e;
    e = Q30_ONE;
    for (int k = 1; k <= n; k++) begin
      e = (e * Q30_RATE + (Q30_ONE >> 1)) >> 30;
    end
    return e;
  endfunction

  localparam logic [63:0] CURVE_SPAN = curve_e(CURVE_LEN - 1) - Q30_ONE;

  function automatic curve_t build_curve();
    logic [63:0] e;
    curve_t      tab;
    e = Q30_ONE;
    for (int k = 0; k < CURVE_LEN; k++) begin
      if (k != 0) begin
        e = (e * Q30_RATE + (Q30_ONE >> 1)) >> 30;
      end
      tab[k] = PMAG_W'((64'd100 * (e - Q30_ONE)) / CURVE_SPAN);
    end
    return tab;
  endfunction

  localparam curve_t CURVE_TAB = build_curve();

endpackage

// File: hdl/analog_stick_conditioner_core.sv
// Top level of the analog stick conditioner: window memory, sequencer and datapath.
//
// Usage: one instance per stick. The input channel (in_valid/in_stall) carries one
// X/Y sample pair per transaction; the result channel (out_valid/out_stall) returns
// one transaction per pair: window means, X/Y percent (Y up positive) and throttle.
// Configuration writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are taken at any
// cycle and must only be issued while no transaction is in flight. Writing a center
// register refills that axis' window with the new center.
// Sequence: window update, mean and dead band, then a 21-step square root and two
// 12-step divider passes; a new pair is accepted only once the previous result has
// been loaded into the output register. When both smoothed offsets fall inside the
// center band the square root and divider passes are skipped.
// The window lives in a one-port synchronous memory read in the cycle before its
// write-back; per-entry valid flops stand in for the center value after reset or a
// center write, so no clearing pass is needed.
// Reset (rst_n low, synchronous) restores the register defaults and a window full of
// the center value.
// A stalled result holds in the output register; the next item is still accepted
// and processed, and waits in the final state until the output register frees.
`include "analog_stick_conditioner_core_macros.svh"

module analog_stick_conditioner_core #(
  parameter int WINDOW_LEN = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [asc_pkg::SAMPLE_BITS-1:0]     in_sample_x,
  input  logic [asc_pkg::SAMPLE_BITS-1:0]     in_sample_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [asc_pkg::SAMPLE_BITS-1:0]     out_smooth_x,
  output logic [asc_pkg::SAMPLE_BITS-1:0]     out_smooth_y,
  output logic signed [asc_pkg::PCT_W-1:0]    out_x_percent,
  output logic signed [asc_pkg::PCT_W-1:0]    out_y_percent,
  output logic signed [asc_pkg::PCT_W-1:0]    out_throttle,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [asc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [asc_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import asc_pkg::*;

  localparam int SLOT_W  = $clog2(WINDOW_LEN);
  localparam int SUM_W   = SAMPLE_BITS + $clog2(WINDOW_LEN);
  localparam int PROD_W  = SAMPLE_BITS + PMAG_W;
  localparam int MEAN_SH = SUM_W + SLOT_W;
  localparam int RCP_W   = SUM_W + 1;
  localparam int MPROD_W = SUM_W + RCP_W;
  localparam logic [SLOT_W-1:0]    SLOT_LAST = SLOT_W'(WINDOW_LEN - 1);
  localparam logic [SUM_W-1:0]     WIN_MUL   = SUM_W'(WINDOW_LEN);
  // rounded-up reciprocal of the window length, exact floor for every sum
  localparam logic [RCP_W-1:0]     MEAN_RCP  =
    RCP_W'(((longint'(1) << MEAN_SH) + longint'(WINDOW_LEN) - 1) / longint'(WINDOW_LEN));

  state_t state_r, state_nxt;

  logic [SAMPLE_BITS-1:0] center_x_r, center_y_r, full_range_r, edge_zone_r;
  logic [DZ_W-1:0]        dead_zone_r;

  logic [2*SAMPLE_BITS-1:0] win_mem [WINDOW_LEN];
  logic [2*SAMPLE_BITS-1:0] rd_data_r;
  logic [SLOT_W-1:0]        slot_r;
  logic [WINDOW_LEN-1:0]    vld_x_r, vld_y_r;
  logic [SUM_W-1:0]         sum_x_r, sum_y_r;

  logic [SAMPLE_BITS-1:0] samp_x_r, samp_y_r, mean_x_r, mean_y_r;
  logic [SAMPLE_BITS-1:0] ax_r, ay_r;
  logic                   neg_x_r, neg_y_r, edge_r;
  logic [R2_W-1:0]        r2_r;
  logic [ROOT_W-1:0]      root_v_r, root_res_r, root_bit_r;
  logic [DIV_DEN_W-1:0]   den_band_r;
  logic [PMAG_W-1:0]      pxm_r, pym_r;
  logic [Q_W-1:0]         q_r;

  logic                   out_valid_r;
  logic [SAMPLE_BITS-1:0] out_smooth_x_r, out_smooth_y_r;
  logic signed [PCT_W-1:0] out_x_percent_r, out_y_percent_r, out_throttle_r;

  logic       in_acc, cfg_we, out_free, div_idle;
  div_req_t   req_x, req_y;
  div_rsp_t   rsp_x, rsp_y;

  logic [SAMPLE_BITS-1:0]         old_x, old_y;
  logic [MPROD_W-1:0]             mprod_x, mprod_y;
  logic signed [SAMPLE_BITS:0]    dbx, dby, eff;
  logic [SAMPLE_BITS-1:0]         abs_x, abs_y, sq_in;
  logic [2*SAMPLE_BITS-1:0]       sq;
  logic [ROOT_W-1:0]              root_t;
  logic                           root_fit, band_edge;
  logic [MAG_W-1:0]               mag, eff_sh;
  logic [PROD_W-1:0]              ax100, ay100;
  logic [DIV_NUM_W-1:0]           num_x, num_y, num_q;
  logic signed [PCT_W-1:0]        px_pos, py_pos, thr_pos;

  function automatic logic signed [SAMPLE_BITS:0] dead_band(
    input logic [SAMPLE_BITS-1:0] m,
    input logic [SAMPLE_BITS-1:0] c,
    input logic [DZ_W-1:0]        z
  );
    logic signed [SAMPLE_BITS+1:0] d, zs;
    d  = $signed({2'b00, m}) - $signed({2'b00, c});
    zs = $signed((SAMPLE_BITS+2)'(z));
    if (d > zs) begin
      return (SAMPLE_BITS+1)'(d - zs);
    end else if (d < -zs) begin
      return (SAMPLE_BITS+1)'(d + zs);
    end
    return '0;
  endfunction

  assign in_acc    = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign div_idle  = !rsp_x.busy && !rsp_y.busy;

  // datapath helpers
  always_comb begin
    old_x    = vld_x_r[slot_r] ? rd_data_r[SAMPLE_BITS-1:0] : center_x_r;
    old_y    = vld_y_r[slot_r] ? rd_data_r[2*SAMPLE_BITS-1:SAMPLE_BITS] : center_y_r;
    mprod_x  = MPROD_W'(sum_x_r) * MPROD_W'(MEAN_RCP);
    mprod_y  = MPROD_W'(sum_y_r) * MPROD_W'(MEAN_RCP);
    dbx      = dead_band(mean_x_r, center_x_r, dead_zone_r);
    dby      = dead_band(mean_y_r, center_y_r, dead_zone_r);
    abs_x    = SAMPLE_BITS'(dbx[SAMPLE_BITS] ? -dbx : dbx);
    abs_y    = SAMPLE_BITS'(dby[SAMPLE_BITS] ? -dby : dby);
    sq_in    = (state_r == ST_SQ_X) ? ax_r : ay_r;
    sq       = (2*SAMPLE_BITS)'(sq_in) * (2*SAMPLE_BITS)'(sq_in);
    root_t   = root_res_r + root_bit_r;
    root_fit = root_v_r >= root_t;
    mag      = root_res_r[MAG_W-1:0];
    eff      = $signed({1'b0, full_range_r}) - $signed({1'b0, edge_zone_r});
    eff_sh   = MAG_W'(eff[SAMPLE_BITS-1:0]) << FRAC_BITS;
    band_edge = eff[SAMPLE_BITS] || (eff == '0) || (mag > eff_sh);
    ax100    = PROD_W'(ax_r) * PROD_W'(PCT_SCALE);
    ay100    = PROD_W'(ay_r) * PROD_W'(PCT_SCALE);
    num_x    = edge_r ? (DIV_NUM_W'(ax100) << FRAC_BITS) : DIV_NUM_W'(ax100);
    num_y    = edge_r ? (DIV_NUM_W'(ay100) << FRAC_BITS) : DIV_NUM_W'(ay100);
    num_q    = edge_r ? (DIV_NUM_W'(ay_r) << (2*FRAC_BITS))
                      : (DIV_NUM_W'(ay_r) << FRAC_BITS);
    px_pos   = PCT_W'(pxm_r);
    py_pos   = PCT_W'(pym_r);
    thr_pos  = PCT_W'(CURVE_TAB[q_r]);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    req_x     = '0;
    req_y     = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_UPD;
      end
      ST_UPD:     state_nxt = ST_MEAN;
      ST_MEAN:    state_nxt = ST_DEAD;
      ST_DEAD: begin
        if (dbx == '0 && dby == '0) begin
          state_nxt = ST_OUT;
        end else begin
          state_nxt = ST_SQ_X;
        end
      end
      ST_SQ_X:      state_nxt = ST_SQ_Y;
      ST_SQ_Y:      state_nxt = ST_ROOT_INIT;
      ST_ROOT_INIT: state_nxt = ST_ROOT;
      ST_ROOT: begin
        if (root_bit_r[0]) state_nxt = ST_BAND;
      end
      ST_BAND:      state_nxt = ST_DIV_GO;
      ST_DIV_GO: begin
        req_x.start = 1'b1;
        req_x.num   = num_x;
        req_x.den   = den_band_r;
        req_y.start = 1'b1;
        req_y.num   = num_y;
        req_y.den   = den_band_r;
        state_nxt   = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_idle) state_nxt = ST_Q_GO;
      end
      ST_Q_GO: begin
        req_x.start = 1'b1;
        req_x.num   = num_q;
        req_x.den   = den_band_r;
        state_nxt   = ST_Q_WAIT;
      end
      ST_Q_WAIT: begin
        if (div_idle) state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      center_x_r   <= CENTER_RST;
      center_y_r   <= CENTER_RST;
      dead_zone_r  <= DEAD_ZONE_RST;
      full_range_r <= FULL_RANGE_RST;
      edge_zone_r  <= EDGE_ZONE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_CENTER_X:   center_x_r   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_CENTER_Y:   center_y_r   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_DEAD_ZONE:  dead_zone_r  <= cfg_data[DZ_W-1:0];
        CFG_FULL_RANGE: full_range_r <= cfg_data[SAMPLE_BITS-1:0];
        CFG_EDGE_ZONE:  edge_zone_r  <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // window state: sums, slot and per-entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_x_r <= SUM_W'(CENTER_RST) * WIN_MUL;
      sum_y_r <= SUM_W'(CENTER_RST) * WIN_MUL;
      vld_x_r <= '0;
      vld_y_r <= '0;
      slot_r  <= '0;
    end else begin
      if (cfg_we && cfg_index == CFG_CENTER_X) begin
        sum_x_r <= SUM_W'(cfg_data[SAMPLE_BITS-1:0]) * WIN_MUL;
        vld_x_r <= '0;
      end
      if (cfg_we && cfg_index == CFG_CENTER_Y) begin
        sum_y_r <= SUM_W'(cfg_data[SAMPLE_BITS-1:0]) * WIN_MUL;
        vld_y_r <= '0;
      end
      if (state_r == ST_UPD) begin
        sum_x_r         <= sum_x_r - SUM_W'(old_x) + SUM_W'(samp_x_r);
        sum_y_r         <= sum_y_r - SUM_W'(old_y) + SUM_W'(samp_y_r);
        vld_x_r[slot_r] <= 1'b1;
        vld_y_r[slot_r] <= 1'b1;
        slot_r          <= (slot_r == SLOT_LAST) ? '0 : slot_r + 1'b1;
      end
    end
  end

  // window memory, read in the cycle before the write-back
  always_ff @(posedge clk) begin
    if (state_r == ST_UPD) begin
      win_mem[slot_r] <= {samp_y_r, samp_x_r};
    end
    rd_data_r <= win_mem[slot_r];
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          samp_x_r <= in_sample_x;
          samp_y_r <= in_sample_y;
        end
      end
      ST_MEAN: begin
        mean_x_r <= SAMPLE_BITS'(mprod_x >> MEAN_SH);
        mean_y_r <= SAMPLE_BITS'(mprod_y >> MEAN_SH);
      end
      ST_DEAD: begin
        ax_r    <= abs_x;
        ay_r    <= abs_y;
        neg_x_r <= dbx[SAMPLE_BITS];
        neg_y_r <= dby[SAMPLE_BITS];
        pxm_r   <= '0;
        pym_r   <= '0;
        q_r     <= '0;
      end
      ST_SQ_X: r2_r <= R2_W'(sq);
      ST_SQ_Y: r2_r <= r2_r + R2_W'(sq);
      ST_ROOT_INIT: begin
        root_v_r   <= ROOT_W'(r2_r) << (2*FRAC_BITS);
        root_res_r <= '0;
        root_bit_r <= ROOT_TOP;
      end
      ST_ROOT: begin
        if (root_fit) begin
          root_v_r   <= root_v_r - root_t;
          root_res_r <= (root_res_r >> 1) + root_bit_r;
        end else begin
          root_res_r <= root_res_r >> 1;
        end
        root_bit_r <= root_bit_r >> 2;
      end
      ST_BAND: begin
        edge_r     <= band_edge;
        den_band_r <= band_edge ? DIV_DEN_W'(mag) : DIV_DEN_W'(eff[SAMPLE_BITS-1:0]);
      end
      ST_DIV_WAIT: begin
        if (div_idle) begin
          pxm_r <= rsp_x.quo[PMAG_W-1:0];
          pym_r <= rsp_y.quo[PMAG_W-1:0];
        end
      end
      ST_Q_WAIT: begin
        if (div_idle) begin
          q_r <= (rsp_x.quo > DIV_QUO_W'(Q_MAX)) ? Q_MAX : rsp_x.quo[Q_W-1:0];
        end
      end
      default: ;
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_OUT && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && out_free) begin
      out_smooth_x_r  <= mean_x_r;
      out_smooth_y_r  <= mean_y_r;
      out_x_percent_r <= neg_x_r ? -px_pos : px_pos;
      out_y_percent_r <= neg_y_r ? py_pos : -py_pos;
      out_throttle_r  <= neg_y_r ? thr_pos : -thr_pos;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_smooth_x  = out_smooth_x_r;
  assign out_smooth_y  = out_smooth_y_r;
  assign out_x_percent = out_x_percent_r;
  assign out_y_percent = out_y_percent_r;
  assign out_throttle  = out_throttle_r;

  asc_div u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_x),
    .rsp   (rsp_x)
  );

  asc_div u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req_y),
    .rsp   (rsp_y)
  );

  `ASC_ASSERT_NEXT(a_accept_starts_update, clk, rst_n, in_valid && !in_stall, state_r == ST_UPD, "accepted transaction did not start the window update")
  `ASC_ASSERT_IMPL(a_div_idle_at_start, clk, rst_n, req_x.start || req_y.start, !rsp_x.busy && !rsp_y.busy, "divider lane started while busy")
  `ASC_ASSERT_IMPL(a_out_load_from_done, clk, rst_n, $rose(out_valid_r), $past(state_r) == ST_OUT, "result register loaded outside the final state")
  `ASC_ASSERT_IMPL(a_slot_in_window, clk, rst_n, 1'b1, slot_r <= SLOT_LAST, "window slot beyond window length")

endmodule

// File: hdl/asc_div.sv
// Restoring divider, one quotient bit per cycle, quotient known to fit DIV_QUO_W bits.
module asc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  asc_pkg::div_req_t req,
  output asc_pkg::div_rsp_t rsp
);
  import asc_pkg::*;

  localparam int SH_W  = DIV_DEN_W + DIV_QUO_W - 1;
  localparam int CNT_W = $clog2(DIV_QUO_W + 1);

  logic [DIV_NUM_W-1:0] rem_r, rem_nxt;
  logic [SH_W-1:0]      dsh_r, dsh_nxt;
  logic [DIV_QUO_W-1:0] quo_r, quo_nxt;
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                 fit;

  always_comb begin
    fit     = SH_W'(rem_r) >= dsh_r;
    rem_nxt = rem_r;
    dsh_nxt = dsh_r;
    quo_nxt = quo_r;
    cnt_nxt = cnt_r;
    if (req.start) begin
      rem_nxt = req.num;
      dsh_nxt = {req.den, (DIV_QUO_W-1)'(0)};
      quo_nxt = '0;
      cnt_nxt = CNT_W'(DIV_QUO_W);
    end else if (cnt_r != '0) begin
      if (fit) begin
        rem_nxt = rem_r - dsh_r[DIV_NUM_W-1:0];
      end
      quo_nxt = {quo_r[DIV_QUO_W-2:0], fit};
      dsh_nxt = dsh_r >> 1;
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsh_r <= dsh_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy = (cnt_r != '0);
  assign rsp.quo  = quo_r;

endmodule
